FILE: hw/rtl/lplim_pkg.sv
`default_nettype none
package lplim_pkg;
    localparam int MAX_CHANNELS  = 8;
    localparam int MAX_LOOKAHEAD = 128;
    localparam int CH_W          = $clog2(MAX_CHANNELS);
    localparam int POS_W         = $clog2(MAX_LOOKAHEAD);
    localparam int DLY_DEPTH     = MAX_LOOKAHEAD * MAX_CHANNELS;
    localparam int DLY_AW        = $clog2(DLY_DEPTH);
    localparam int SAMPLE_W      = 24;
    localparam int GAIN_W        = 25;
    localparam int LEN_W         = 8;
    localparam int CHN_W         = 4;
    localparam int CFG_IDX_W     = 4;
    localparam int DVD_W         = 48;
    localparam int DVS_W         = 24;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = 25'd16777216;
    localparam logic [GAIN_W-1:0] THR_MIN   = 25'd838861;
    localparam logic [GAIN_W-1:0] REL_RESET = 25'd2912;
    localparam logic [LEN_W-1:0]  LEN_RESET = 8'd72;
    localparam logic [CHN_W-1:0]  CHN_RESET = 4'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 4'd3;
endpackage
`default_nettype wire

FILE: hw/rtl/lplim_div.sv
`default_nettype none
module lplim_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [lplim_pkg::DVD_W-1:0]       dividend,
    input  wire logic [lplim_pkg::DVS_W-1:0]       divisor,
    output logic                                   done,
    output logic [lplim_pkg::GAIN_W-1:0]           quotient
);
    localparam int STEPS = lplim_pkg::DVD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [lplim_pkg::DVD_W-1:0] dvd_reg;
    logic [lplim_pkg::DVS_W-1:0] dvs_reg;
    logic [lplim_pkg::DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [lplim_pkg::DVS_W:0]   rem_sh;
    logic                        qbit;

    // One quotient bit per cycle; the dividend register fills with quotient bits.
    always_comb begin
        rem_sh = {rem_reg, dvd_reg[lplim_pkg::DVD_W-1]};
        qbit   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= qbit ? lplim_pkg::DVS_W'(rem_sh - {1'b0, dvs_reg})
                                : rem_sh[lplim_pkg::DVS_W-1:0];
                dvd_reg <= {dvd_reg[lplim_pkg::DVD_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[lplim_pkg::GAIN_W-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/lplim_scale.sv
`default_nettype none
module lplim_scale (
    input  wire logic                                 aclk,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0] d,
    input  wire logic        [lplim_pkg::GAIN_W-1:0]   g,
    output logic signed      [lplim_pkg::SAMPLE_W-1:0] y
);
    logic signed [49:0] prod_reg;
    logic signed [50:0] rnd;
    logic signed [26:0] shr;

    always_ff @(posedge aclk) begin
        prod_reg <= d * $signed({1'b0, g});
    end

    // Round half up, then saturate to the sample range.
    always_comb begin
        rnd = {prod_reg[49], prod_reg} + 51'sd8388608;
        shr = rnd[50:24];
        if (shr > 27'sd8388607) begin
            y = 24'sh7FFFFF;
        end else if (shr < -27'sd8388608) begin
            y = 24'sh800000;
        end else begin
            y = shr[lplim_pkg::SAMPLE_W-1:0];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/lookahead_peak_limiter_unit.sv
`default_nettype none
// Each frame runs a peak search, a gain divide when the peak exceeds half the threshold, a scan
// of the gain ring, a gain update (a divide on a falling gain), and a scaling pass per channel.
// One frame is in work at a time; a new one is taken once the previous result is registered.
// A clear request finishes through ST_FIN and then starts a clearing pass over the memories.
// After reset, and after a write to lookahead_len or channels_in_use, the same clearing pass
// runs; no frame is accepted until it ends. Configuration writes are always taken.
module lookahead_peak_limiter_unit (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    s_cmd,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_0,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_1,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_2,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_3,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_4,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_5,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_6,
    input  wire logic signed [lplim_pkg::SAMPLE_W-1:0]   s_sample_7,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_0,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_1,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_2,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_3,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_4,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_5,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_6,
    output logic signed [lplim_pkg::SAMPLE_W-1:0]        m_out_7,
    output logic [lplim_pkg::GAIN_W-1:0]                 m_gain_now,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [lplim_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [lplim_pkg::GAIN_W-1:0]            cfg_data
);
    localparam int SW = lplim_pkg::SAMPLE_W;
    localparam int GW = lplim_pkg::GAIN_W;
    localparam int NCH = lplim_pkg::MAX_CHANNELS;

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_PEAK  = 13'b0000000000100,
        ST_DIV1  = 13'b0000000001000,
        ST_SCAN  = 13'b0000000010000,
        ST_UPD   = 13'b0000000100000,
        ST_DIV2  = 13'b0000001000000,
        ST_RISE  = 13'b0000010000000,
        ST_RADD  = 13'b0000100000000,
        ST_CHRD  = 13'b0001000000000,
        ST_CHMUL = 13'b0010000000000,
        ST_CHSAT = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [GW-1:0]                   thr_reg, rel_reg;
    logic [lplim_pkg::LEN_W-1:0]     len_reg;
    logic [lplim_pkg::CHN_W-1:0]     chn_reg;
    logic [GW-1:0]                   thr_c, rel_c;
    logic [lplim_pkg::LEN_W-1:0]     len_c;
    logic [lplim_pkg::CHN_W-1:0]     chn_c;

    // Memories.
    logic signed [SW-1:0] dly_mem [lplim_pkg::DLY_DEPTH];
    logic [GW-1:0]        ring_mem [lplim_pkg::MAX_LOOKAHEAD];
    logic signed [SW-1:0] dly_rd_reg;
    logic [GW-1:0]        ring_rd_reg;
    logic                 dly_we, ring_we;
    logic [lplim_pkg::DLY_AW-1:0] dly_addr;
    logic signed [SW-1:0] dly_wdata;
    logic [lplim_pkg::POS_W-1:0]  ring_waddr, ring_raddr;
    logic [GW-1:0]        ring_wdata;

    // Frame state.
    logic signed [SW-1:0]          smp_reg [NCH];
    logic signed [SW-1:0]          res_reg [NCH];
    logic signed [SW-1:0]          in_smp  [NCH];
    logic                          clr_pend_reg;
    logic [lplim_pkg::DLY_AW-1:0]  clr_cnt_reg;
    logic [lplim_pkg::POS_W-1:0]   ring_pos_reg, pos_reg;
    logic [GW-1:0]                 gain_reg, fall_reg, target_reg, diff_reg;
    logic [lplim_pkg::LEN_W-1:0]   scan_idx_reg;
    logic                          scan_vld_reg;
    logic [lplim_pkg::CHN_W-1:0]   ch_reg;
    logic [49:0]                   prod_reg;

    logic signed [SW-1:0] o_reg [NCH];
    logic [GW-1:0]        o_gain_reg;
    logic                 m_valid_reg;

    // Peak search and update arithmetic.
    logic [SW-1:0]    peak, abs_v;
    logic             div_start, div_done;
    logic [lplim_pkg::DVD_W-1:0] div_dvd;
    logic [lplim_pkg::DVS_W-1:0] div_dvs;
    logic [GW-1:0]    div_q;
    logic [GW-1:0]    fall_n;
    logic [50:0]      up_sum;
    logic [26:0]      gsum;
    logic [25:0]      ceil_num;
    logic signed [SW-1:0] scale_y;
    logic             accept, cfg_geo, out_free;

    assign in_smp[0] = s_sample_0;
    assign in_smp[1] = s_sample_1;
    assign in_smp[2] = s_sample_2;
    assign in_smp[3] = s_sample_3;
    assign in_smp[4] = s_sample_4;
    assign in_smp[5] = s_sample_5;
    assign in_smp[6] = s_sample_6;
    assign in_smp[7] = s_sample_7;

    always_comb begin
        thr_c = (thr_reg < lplim_pkg::THR_MIN) ? lplim_pkg::THR_MIN :
                (thr_reg > lplim_pkg::GAIN_ONE) ? lplim_pkg::GAIN_ONE : thr_reg;
        rel_c = (rel_reg > lplim_pkg::GAIN_ONE) ? lplim_pkg::GAIN_ONE : rel_reg;
        len_c = (len_reg == '0) ? lplim_pkg::LEN_W'(1) :
                (len_reg > lplim_pkg::LEN_W'(lplim_pkg::MAX_LOOKAHEAD)) ?
                lplim_pkg::LEN_W'(lplim_pkg::MAX_LOOKAHEAD) : len_reg;
        chn_c = (chn_reg == '0) ? lplim_pkg::CHN_W'(1) :
                (chn_reg > lplim_pkg::CHN_W'(NCH)) ? lplim_pkg::CHN_W'(NCH) : chn_reg;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_geo   = cfg_valid && ((cfg_index == lplim_pkg::REG_LOOKAHEAD) ||
                                     (cfg_index == lplim_pkg::REG_CHANNELS));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        peak = '0;
        for (int c = 0; c < NCH; c++) begin
            abs_v = smp_reg[c][SW-1] ? SW'(~smp_reg[c] + 1'b1) : SW'(smp_reg[c]);
            if ((lplim_pkg::CHN_W'(c) < chn_c) && (abs_v > peak)) begin
                peak = abs_v;
            end
        end
    end

    always_comb begin
        // The fall step divide starts in the same cycle that diff_reg is loaded.
        ceil_num  = 26'(gain_reg - target_reg) + 26'(len_c) - 26'd1;
        div_start = 1'b0;
        div_dvd   = {thr_c, 23'b0};
        div_dvs   = peak;
        if (state_reg == ST_PEAK) begin
            div_start = (peak != '0) && ({peak, 1'b0} > thr_c);
        end else if (state_reg == ST_UPD) begin
            div_start = (target_reg < gain_reg);
            div_dvd   = {22'b0, ceil_num};
            div_dvs   = lplim_pkg::DVS_W'(len_c);
        end
        fall_n = (div_q > fall_reg) ? div_q : fall_reg;
        up_sum = {1'b0, prod_reg} + 51'(lplim_pkg::GAIN_ONE - 1'b1);
        gsum   = {2'b0, gain_reg} + up_sum[50:24];
    end

    lplim_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    lplim_scale u_scale (
        .aclk (aclk),
        .d    (dly_rd_reg),
        .g    (gain_reg),
        .y    (scale_y)
    );

    // Memory port steering.
    always_comb begin
        dly_we     = 1'b0;
        dly_addr   = {pos_reg, ch_reg[lplim_pkg::CH_W-1:0]};
        dly_wdata  = smp_reg[ch_reg[lplim_pkg::CH_W-1:0]];
        ring_we    = 1'b0;
        ring_waddr = pos_reg;
        ring_wdata = lplim_pkg::GAIN_ONE;
        ring_raddr = scan_idx_reg[lplim_pkg::POS_W-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                dly_we     = 1'b1;
                dly_addr   = clr_cnt_reg;
                dly_wdata  = '0;
                ring_we    = 1'b1;
                ring_waddr = clr_cnt_reg[lplim_pkg::POS_W-1:0];
            end
            ST_PEAK: begin
                ring_we = !div_start;
            end
            ST_DIV1: begin
                ring_we    = div_done;
                ring_wdata = div_q;
            end
            ST_CHRD: begin
                dly_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dly_we) begin
            dly_mem[dly_addr] <= dly_wdata;
        end
        dly_rd_reg <= dly_mem[dly_addr];
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            thr_reg      <= lplim_pkg::GAIN_ONE;
            rel_reg      <= lplim_pkg::REL_RESET;
            len_reg      <= lplim_pkg::LEN_RESET;
            chn_reg      <= lplim_pkg::CHN_RESET;
            ring_pos_reg <= '0;
            gain_reg     <= lplim_pkg::GAIN_ONE;
            fall_reg     <= '0;
            clr_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            scan_vld_reg <= 1'b0;
            scan_idx_reg <= '0;
            ch_reg       <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        for (int c = 0; c < NCH; c++) begin
                            smp_reg[c] <= in_smp[c];
                            res_reg[c] <= '0;
                        end
                        pos_reg <= ({1'b0, ring_pos_reg} < len_c) ? ring_pos_reg : '0;
                        ch_reg  <= '0;
                        if (s_cmd) begin
                            clr_pend_reg <= 1'b1;
                            gain_reg     <= lplim_pkg::GAIN_ONE;
                            fall_reg     <= '0;
                            state_reg    <= ST_FIN;
                        end else begin
                            clr_pend_reg <= 1'b0;
                            state_reg    <= ST_PEAK;
                        end
                    end
                end
                ST_PEAK: begin
                    scan_idx_reg <= '0;
                    scan_vld_reg <= 1'b0;
                    target_reg   <= lplim_pkg::GAIN_ONE;
                    state_reg    <= div_start ? ST_DIV1 : ST_SCAN;
                end
                ST_DIV1: begin
                    if (div_done) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Reads are issued one a cycle; data comes back in the following cycle.
                    scan_vld_reg <= (scan_idx_reg < len_c);
                    if (scan_idx_reg < len_c) begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (scan_vld_reg && (ring_rd_reg < target_reg)) begin
                        target_reg <= ring_rd_reg;
                    end
                    if ((scan_idx_reg == len_c) && !scan_vld_reg) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (target_reg < gain_reg) begin
                        diff_reg  <= gain_reg - target_reg;
                        state_reg <= ST_DIV2;
                    end else begin
                        diff_reg  <= target_reg - gain_reg;
                        state_reg <= ST_RISE;
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        fall_reg  <= fall_n;
                        gain_reg  <= (diff_reg > fall_n) ? gain_reg - fall_n : target_reg;
                        state_reg <= ST_CHRD;
                    end
                end
                ST_RISE: begin
                    prod_reg  <= diff_reg * rel_c;
                    state_reg <= ST_RADD;
                end
                ST_RADD: begin
                    fall_reg  <= '0;
                    gain_reg  <= (gsum > {2'b0, target_reg}) ? target_reg : gsum[GW-1:0];
                    state_reg <= ST_CHRD;
                end
                ST_CHRD: begin
                    state_reg <= ST_CHMUL;
                end
                ST_CHMUL: begin
                    state_reg <= ST_CHSAT;
                end
                ST_CHSAT: begin
                    res_reg[ch_reg[lplim_pkg::CH_W-1:0]] <= scale_y;
                    ch_reg <= ch_reg + 1'b1;
                    state_reg <= ((ch_reg + 1'b1) == chn_c) ? ST_FIN : ST_CHRD;
                end
                ST_FIN: begin
                    if (out_free) begin
                        for (int c = 0; c < NCH; c++) begin
                            o_reg[c] <= res_reg[c];
                        end
                        o_gain_reg  <= gain_reg;
                        m_valid_reg <= 1'b1;
                        if (clr_pend_reg) begin
                            ring_pos_reg <= '0;
                            clr_cnt_reg  <= '0;
                            state_reg    <= ST_CLEAR;
                        end else begin
                            ring_pos_reg <= ((9'(pos_reg) + 9'd1) >= 9'(len_c)) ? '0 :
                                            pos_reg + 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase

            if (cfg_valid) begin
                unique case (cfg_index)
                    lplim_pkg::REG_THRESHOLD: thr_reg <= cfg_data;
                    lplim_pkg::REG_RELEASE:   rel_reg <= cfg_data;
                    lplim_pkg::REG_LOOKAHEAD: len_reg <= cfg_data[lplim_pkg::LEN_W-1:0];
                    lplim_pkg::REG_CHANNELS:  chn_reg <= cfg_data[lplim_pkg::CHN_W-1:0];
                    default: begin
                    end
                endcase
            end
            // A geometry change restarts the clearing pass.
            if (cfg_geo) begin
                state_reg    <= ST_CLEAR;
                clr_cnt_reg  <= '0;
                ring_pos_reg <= '0;
                gain_reg     <= lplim_pkg::GAIN_ONE;
                fall_reg     <= '0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_0    = o_reg[0];
    assign m_out_1    = o_reg[1];
    assign m_out_2    = o_reg[2];
    assign m_out_3    = o_reg[3];
    assign m_out_4    = o_reg[4];
    assign m_out_5    = o_reg[5];
    assign m_out_6    = o_reg[6];
    assign m_out_7    = o_reg[7];
    assign m_gain_now = o_gain_reg;
endmodule
`default_nettype wire
